// File: sv/complementary_tilt_filter_defines.svh
// Assertion macros shared by the checker of the complementary tilt filter.
// No dependencies.
`ifndef COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
`define COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CTF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define CTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/ctf_pkg.sv
// Types and constants of the complementary tilt filter.
// No dependencies.
`default_nettype none
package ctf_pkg;
  localparam int ANG_W = 26;
  localparam int CV_W = 40;
  localparam logic [1:0] REG_SHIFT = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;
  localparam logic [1:0] REG_WEIGHT = 2'd2;
  localparam logic signed [ANG_W-1:0] ANG_90 = 26'sd5898240;

  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      5'd0: r = 26'sd2949120;  5'd1: r = 26'sd1740967;  5'd2: r = 26'sd919879;
      5'd3: r = 26'sd466945;   5'd4: r = 26'sd234379;   5'd5: r = 26'sd117304;
      5'd6: r = 26'sd58666;    5'd7: r = 26'sd29335;    5'd8: r = 26'sd14668;
      5'd9: r = 26'sd7334;     5'd10: r = 26'sd3667;    5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;     5'd13: r = 26'sd458;     5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;     5'd16: r = 26'sd57;      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;      5'd19: r = 26'sd7;       5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;       5'd22: r = 26'sd1;       default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: sv/ctf_cordic.sv
// One CORDIC lane: iterative vectoring atan2 in degrees Q16, one step a cycle.
// Depends on ctf_pkg.
`default_nettype none
module ctf_cordic import ctf_pkg::*; #(
  parameter int ITER = 16,
  parameter int IN_W = 34
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire signed [IN_W-1:0]  y_in,
  input  wire signed [IN_W-1:0]  x_in,
  output logic                   done,
  output logic signed [ANG_W-1:0] angle
);
  localparam int N = (ITER > 24) ? 24 : ITER;
  localparam int W = IN_W + 3;
  logic signed [W-1:0] x, y;
  logic [4:0] step;
  logic busy;
  logic signed [W-1:0] xe, ye, dx, dy;

  assign xe = W'(x_in);
  assign ye = W'(y_in);
  assign dx = y >>> step;
  assign dy = x >>> step;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      step <= '0;
      if (x_in == '0 && y_in == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
        angle <= '0;
        x <= '0;
        y <= '0;
      end else begin
        busy <= 1'b1;
        if (x_in < 0) begin
          if (y_in >= 0) begin
            x <= ye; y <= -xe; angle <= ANG_90;
          end else begin
            x <= -ye; y <= xe; angle <= -ANG_90;
          end
        end else begin
          x <= xe; y <= ye; angle <= '0;
        end
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + dx; y <= y - dy; angle <= angle + atan_tab(step);
      end else begin
        x <= x - dx; y <= y + dy; angle <= angle - atan_tab(step);
      end
      if (step == 5'(N - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      step <= step + 5'd1;
    end
  end
endmodule
`default_nettype wire

// File: sv/ctf_merge.sv
// Merging stage: blends both lane angles into their estimates and computes energy.
// Depends on ctf_pkg.
`default_nettype none
module ctf_merge import ctf_pkg::*; #(
  parameter int FRAC = 16,
  parameter int S_W = 34
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire signed [S_W-1:0]    sx,
  input  wire signed [S_W-1:0]    sy,
  input  wire signed [S_W-1:0]    sz,
  input  wire signed [ANG_W-1:0]  pitch_acc,
  input  wire signed [ANG_W-1:0]  roll_acc,
  input  wire signed [15:0]       gyro_p,
  input  wire signed [15:0]       gyro_r,
  input  wire [23:0]              gain,
  input  wire [16:0]              weight,
  output logic                    done,
  output logic signed [24:0]      pitch_est,
  output logic signed [24:0]      roll_est,
  output logic [22:0]             energy
);
  localparam int G = (FRAC > 16) ? 16 : FRAC;
  localparam int ESH = 2 * G + 8;
  localparam int T_W = S_W - (FRAC - G);
  localparam logic [7:0] STAGES = 8'd13;
  logic [7:0] ph;
  logic busy;
  logic signed [T_W-1:0] tsel;
  logic signed [35:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [71:0] prod;
  logic signed [71:0] prod_q;
  logic [69:0] sum;
  logic [23:0] esum;
  logic [47:0] eprod;
  logic signed [42:0] tacc;
  logic signed [24:0] t_hi;
  logic [17:0] t_lo;
  logic signed [63:0] bacc;
  logic signed [63:0] rnd;
  logic [16:0] w;
  logic sel_roll;

  assign w = (weight > 17'd65536) ? 17'd65536 : weight;
  assign rnd = (bacc + 64'(prod_q <<< 8) + 64'sd8388608) >>> 24;
  assign t_hi = tacc[42:18];
  assign t_lo = tacc[17:0];

  // The shifted sum is below 2^25, so a reciprocal multiply divides it by three exactly.
  assign esum = 24'(sum >> ESH);
  assign eprod = {24'd0, esum} * 48'd11184811;

  always_comb begin
    unique case (ph[1:0])
      2'd0: tsel = T_W'(sx >>> (FRAC - G));
      2'd1: tsel = T_W'(sy >>> (FRAC - G));
      default: tsel = T_W'(sz >>> (FRAC - G));
    endcase
  end

  // Phases 0-2 square the axes, 3-7 blend pitch and 8-12 blend roll.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ph)
      8'd0, 8'd1, 8'd2: begin mul_a = 36'(tsel); mul_b = 36'(tsel); end
      8'd3: begin mul_a = 36'(gyro_p); mul_b = 36'($signed({1'b0, gain})); end
      8'd5, 8'd10: begin mul_a = 36'(t_hi); mul_b = 36'($signed({1'b0, w})); end
      8'd6, 8'd11: begin
        mul_a = 36'($signed({1'b0, t_lo})); mul_b = 36'($signed({1'b0, w}));
      end
      8'd7: begin
        mul_a = 36'(pitch_acc); mul_b = 36'($signed(18'(65536) - {1'b0, w}));
      end
      8'd8: begin mul_a = 36'(gyro_r); mul_b = 36'($signed({1'b0, gain})); end
      8'd12: begin
        mul_a = 36'(roll_acc); mul_b = 36'($signed(18'(65536) - {1'b0, w}));
      end
      default: ;
    endcase
  end
  assign prod = mul_a * mul_b;
  assign sel_roll = (ph >= 8'd8);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    prod_q <= prod;
    if (rst) begin
      busy <= 1'b0;
      ph <= '0;
      pitch_est <= '0;
      roll_est <= '0;
    end else if (start) begin
      busy <= 1'b1;
      ph <= '0;
      sum <= '0;
    end else if (busy) begin
      ph <= ph + 8'd1;
      if (ph >= 8'd1 && ph <= 8'd3) sum <= sum + 70'(prod_q);
      if (ph == 8'd4)
        energy <= (eprod[47:25] > 23'd4194304) ? 23'd4194304 : eprod[47:25];
      if (ph == 8'd4 || ph == 8'd9)
        tacc <= 43'((sel_roll ? 43'(roll_est) : 43'(pitch_est)) <<< 8) + 43'(prod_q);
      if (ph == 8'd6 || ph == 8'd11) bacc <= 64'(prod_q) <<< 18;
      if (ph == 8'd7 || ph == 8'd12) bacc <= bacc + 64'(prod_q);
      if (ph == 8'd8 || ph == 8'd13) begin
        if (rnd > 64'sd16777215) begin
          if (ph == 8'd8) pitch_est <= 25'sd16777215; else roll_est <= 25'sd16777215;
        end else if (rnd < -64'sd16777216) begin
          if (ph == 8'd8) pitch_est <= -25'sd16777216; else roll_est <= -25'sd16777216;
        end else begin
          if (ph == 8'd8) pitch_est <= 25'(rnd);
          else roll_est <= 25'(rnd);
        end
      end
      if (ph == STAGES) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/complementary_tilt_filter.sv
// Top level of the complementary tilt filter: registers, smoothing, two CORDIC lanes, merge.
// Depends on ctf_pkg, ctf_cordic and ctf_merge.
//   channel  dir  contents
//   s_axis   in   acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
//   m_axis   out  pitch_deg, roll_deg, acc_energy, rate_roll, rate_pitch, rate_yaw
//   apb      in   acc_smooth_shift, gyro_gain_q24, blend_weight_q16
// A word is taken only in idle: the smoothing is registered and both lanes are started,
// the CORDIC steps follow, then the merge phases, then the result is loaded for output.
// A lane with an all-zero vector skips its steps; the other lane sets the pace.
// Reset clears the state and sets registers to defaults; a result waits in the output
// register while the next word is taken; a stalled m_axis only delays the next hand-over.
`default_nettype none
module complementary_tilt_filter import ctf_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ACCEL_FRAC_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [95:0]  s_axis_tdata,   // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // pitch, roll, energy, rate_roll/pitch/yaw, zero pad
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [3:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int S_W = 18 + ACCEL_FRAC_BITS;
  localparam logic [1:0] ST_IDLE = 2'd0, ST_COR = 2'd1, ST_MRG = 2'd2, ST_OUT = 2'd3;
  logic [1:0] state;
  logic [3:0] shift;
  logic [23:0] gain;
  logic [16:0] weight;
  logic signed [S_W-1:0] s [3];
  logic signed [15:0] gx, gy, gz;
  logic cstart, pdone, rdone, mstart, mdone;
  logic pflag, rflag, load_out;
  logic signed [ANG_W-1:0] pang, rang;
  logic signed [24:0] pe, re;
  logic [22:0] en;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];
  always_comb begin
    unique case (ridx)
      REG_SHIFT: prdata = {28'd0, shift};
      REG_GAIN: prdata = {8'd0, gain};
      REG_WEIGHT: prdata = {15'd0, weight};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= '0;
      gain <= 24'd10234;
      weight <= 17'd64881;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_SHIFT: shift <= pwdata[3:0];
        REG_GAIN: gain <= pwdata[23:0];
        REG_WEIGHT: weight <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign load_out = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    cstart <= 1'b0;
    mstart <= 1'b0;
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int a = 0; a < 3; a++) s[a] <= '0;
    end else begin
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {7'd0, gz, gy, gx, en, re, pe};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          for (int a = 0; a < 3; a++)
            s[a] <= s[a] + ((($signed({s_axis_tdata[16*a+:16], {ACCEL_FRAC_BITS{1'b0}}})
                     - s[a])) >>> shift);
          gx <= s_axis_tdata[63:48];
          gy <= s_axis_tdata[79:64];
          gz <= s_axis_tdata[95:80];
          pflag <= 1'b0;
          rflag <= 1'b0;
          cstart <= 1'b1;
          state <= ST_COR;
        end
        ST_COR: begin
          if ((pdone || pflag) && (rdone || rflag)) begin
            mstart <= 1'b1;
            state <= ST_MRG;
          end else begin
            pflag <= pflag | pdone;
            rflag <= rflag | rdone;
          end
        end
        ST_MRG: if (mdone) begin
          state <= ST_OUT;
        end
        ST_OUT: if (load_out) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ctf_cordic #(.ITER(CORDIC_ITERATIONS), .IN_W(S_W)) u_pitch (
    .clk(clk), .rst(rst), .start(cstart), .y_in(s[0]), .x_in(s[2]),
    .done(pdone), .angle(pang));
  ctf_cordic #(.ITER(CORDIC_ITERATIONS), .IN_W(S_W)) u_roll (
    .clk(clk), .rst(rst), .start(cstart), .y_in(s[1]), .x_in(s[2]),
    .done(rdone), .angle(rang));
  ctf_merge #(.FRAC(ACCEL_FRAC_BITS), .S_W(S_W)) u_merge (
    .clk(clk), .rst(rst), .start(mstart), .sx(s[0]), .sy(s[1]), .sz(s[2]),
    .pitch_acc(-pang), .roll_acc(rang), .gyro_p(gy), .gyro_r(gx), .gain(gain),
    .weight(weight), .done(mdone), .pitch_est(pe), .roll_est(re), .energy(en));
endmodule
`default_nettype wire

// File: sv/ctf_checker.sv
// Port checker for the complementary tilt filter, bound to the top level.
// Depends on complementary_tilt_filter_defines.svh.
`default_nettype none
`include "complementary_tilt_filter_defines.svh"
module ctf_checker (
  input wire clk,
  input wire rst,
  input wire s_axis_tvalid,
  input wire s_axis_tready,
  input wire m_axis_tvalid,
  input wire m_axis_tready,
  input wire pready
);
  `CTF_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CTF_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CTF_ASSERT_IMPL(a_ready_apb, 1'b1, pready)
endmodule
bind complementary_tilt_filter ctf_checker u_chk (.*);
`default_nettype wire

// File: sim/tb_complementary_tilt_filter.sv
// Testbench for the complementary tilt filter: drives sensor words, writes registers over APB,
// and checks every output word against a built-in predictor. Depends on ctf_pkg and the RTL.
`timescale 1ns / 1ps
module tb_complementary_tilt_filter;
  import ctf_pkg::*;

  typedef struct packed {
    logic signed [15:0] gz, gy, gx, az, ay, ax;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] ryaw, rpitch, rroll;
    logic [22:0] energy;
    logic signed [24:0] roll;
    logic signed [24:0] pitch;
  } tilt_t;

  localparam int LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;  // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [127:0] m_axis_tdata;      // pitch, roll, energy, rate_roll, rate_pitch, rate_yaw
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  complementary_tilt_filter u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  logic [3:0] shift_q;
  logic [23:0] gain_q;
  logic [16:0] weight_q;
  longint smooth_q [3];
  longint pitch_est, roll_est;
  tilt_t tilt_fifo [$];
  int errors = 0;
  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("complementary_tilt_filter: mismatch");
      $finish;
    end
  end

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint tilt_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = ANG_90;
      end else begin
        x = -y; y = t; z = -ANG_90;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_tab(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_tab(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic longint blend_angle(longint est, longint rate, longint ang);
    longint w, t, a, r;
    w = (weight_q > 65536) ? 65536 : weight_q;
    t = est * 256 + rate * longint'(gain_q);
    a = w * t + (65536 - w) * (ang * 256);
    r = sra(a + (64'sd1 <<< 23), 24);
    if (r > 16777215) r = 16777215;
    if (r < -16777216) r = -16777216;
    return r;
  endfunction

  function automatic tilt_t predict_tilt(sample_t s);
    tilt_t o;
    longint raw [3];
    longint sum, e;
    raw[0] = s.ax; raw[1] = s.ay; raw[2] = s.az;
    sum = 0;
    for (int a = 0; a < 3; a++) begin
      smooth_q[a] += sra(raw[a] * 65536 - smooth_q[a], shift_q);
      sum += smooth_q[a] * smooth_q[a];
    end
    e = longint'(unsigned'(sum) / (64'd196608 << 24));
    if (e > 4194304) e = 4194304;
    pitch_est = blend_angle(pitch_est, s.gy, -tilt_atan2(smooth_q[0], smooth_q[2]));
    roll_est = blend_angle(roll_est, s.gx, tilt_atan2(smooth_q[1], smooth_q[2]));
    o.pitch = pitch_est[24:0];
    o.roll = roll_est[24:0];
    o.energy = e[22:0];
    o.rroll = s.gx; o.rpitch = s.gy; o.ryaw = s.gz;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Sum of squares can reach about 1.4e19, beyond signed 64 bits; read it as unsigned, which matches
  // the hardware since each square fits and the sum fits unsigned.
  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_SHIFT: shift_q = val[3:0];
      REG_GAIN: gain_q = val[23:0];
      default: weight_q = val[16:0];
    endcase
  endtask

  task automatic send_word(sample_t s, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= s;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tilt_fifo.push_back(predict_tilt(s));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (tilt_fifo.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    s = {$urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) == 0) s.az = 0;
    if ($urandom_range(0, 5) == 0) begin
      s.ax = 0; s.az = 0;
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(0, 99) < ((cycles / 500) % 2 ? 100 : 60));
  end

  always @(posedge clk) begin
    tilt_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[120:0];
      if (tilt_fifo.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = tilt_fifo.pop_front();
        if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
        if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
        if (got.energy !== want.energy) report_mismatch("energy", got.energy, want.energy);
        if (got.rroll !== want.rroll) report_mismatch("rate_roll", got.rroll, want.rroll);
        if (got.rpitch !== want.rpitch) report_mismatch("rate_pitch", got.rpitch, want.rpitch);
        if (got.ryaw !== want.ryaw) report_mismatch("rate_yaw", got.ryaw, want.ryaw);
      end
    end
  end

  sample_t directed [20];
  logic [31:0] cfg_set [5][3];

  initial begin
    shift_q = 0; gain_q = 10234; weight_q = 64881;
    smooth_q = '{0, 0, 0}; pitch_est = 0; roll_est = 0;
    directed[0] = '0;
    directed[1] = {16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd0};
    directed[2] = {16'sd0, 16'sd0, 16'sd0, -16'sd100, 16'sd0, 16'sd0};
    directed[3] = {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd50, 16'sd0};
    directed[4] = {16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd50, -16'sd50};
    directed[5] = {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd70};
    directed[6] = {16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    directed[7] = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    directed[8] = {16'sh7fff, 16'sh8000, 16'sh7fff, -16'sh7fff, 16'sh8000, 16'sh7fff};
    directed[9] = {16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000};
    for (int i = 10; i < 20; i++) directed[i] = {16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0,
                                                16'sd0, 16'sd1000};
    cfg_set[0] = '{32'd8, 32'hffffff, 32'd65536};
    cfg_set[1] = '{32'd15, 32'd0, 32'd0};
    cfg_set[2] = '{32'd3, 32'd10234, 32'h1ffff};
    cfg_set[3] = '{32'd9, 32'd500000, 32'd32768};
    cfg_set[4] = '{32'd1, 32'd10234, 32'd64881};

    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int i = 0; i < 20; i++) send_word(directed[i], 0);
    drain();

    for (int p = 0; p < 5; p++) begin
      for (int r = 0; r < 3; r++) apb_write(r[1:0], cfg_set[p][r]);
      if (p == 0) begin
        for (int i = 0; i < 20; i++) send_word(directed[i], 0);
      end
      for (int i = 0; i < 160; i++) send_word(rand_sample(), (p % 2) == 0);
      drain();
    end

    if (errors == 0) begin
      $display("complementary_tilt_filter: match");
    end else begin
      $display("complementary_tilt_filter: mismatch");
    end
    $finish;
  end
endmodule
